### sv/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive regulator package
// Widths, register indexes, reset values and the structs that pass between
// the sequencer and the shared bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package pdr_pkg;

   localparam int ERR_W     = 32;
   localparam int MS_W      = 16;
   localparam int GAIN_W    = 16;
   localparam int THR_W     = 9;
   localparam int LIM_W     = 8;
   localparam int DRIVE_W   = 9;
   localparam int INTEG_W   = 48;
   localparam int Q_SHIFT   = 24;
   localparam int DIFF_W    = ERR_W + 1;

   // Multiplier: signed A by unsigned B, one bit of B per cycle.
   localparam int MUL_A_W   = 49;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Divider: signed dividend by unsigned divisor, one quotient bit per cycle.
   localparam int DIV_N_W   = 59;
   localparam int DIV_MAG_W = DIV_N_W - 1;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_MAG_W);

   localparam int SUM_W     = 65;
   localparam int WHOLE_W   = SUM_W - Q_SHIFT;

   localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);

   // Configuration port
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_THR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIM  = 3'd4;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd11520;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd25600;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd640;
   localparam logic [THR_W-1:0]  INTEG_THR_RST  = 9'd25;
   localparam logic [LIM_W-1:0]  OUTPUT_LIM_RST = 8'd255;

   typedef struct packed {
      logic                       start;
      logic signed [MUL_A_W-1:0]  a;
      logic [MUL_B_W-1:0]         b;
   } mul_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [MUL_P_W-1:0]  product;
   } mul_rsp_type;

   typedef struct packed {
      logic                       start;
      logic signed [DIV_N_W-1:0]  dividend;
      logic [DIV_D_W-1:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [DIV_N_W-1:0]  quotient;
   } div_rsp_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_P_MUL  = 10'b00_0000_0010,
      ST_E_MUL  = 10'b00_0000_0100,
      ST_I_DIV  = 10'b00_0000_1000,
      ST_I_UPD  = 10'b00_0001_0000,
      ST_I_MUL  = 10'b00_0010_0000,
      ST_D_MUL1 = 10'b00_0100_0000,
      ST_D_MUL2 = 10'b00_1000_0000,
      ST_D_DIV  = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

endpackage

### sv/pdr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive regulator channels
// Valid/ready channels for error samples in and drive values out.
// ----------------------------------------------------------------------------
interface pdr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdr_pkg::ERR_W-1:0]     error_sample;
   logic [pdr_pkg::MS_W-1:0]             elapsed_ms;
   logic                                 restart;

   modport source (output valid, output error_sample, output elapsed_ms,
                   output restart, input ready);
   modport sink   (input valid, input error_sample, input elapsed_ms,
                   input restart, output ready);
endinterface

interface pdr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdr_pkg::DRIVE_W-1:0]   drive;
   logic                                 clamped;

   modport source (output valid, output drive, output clamped, input ready);
   modport sink   (input valid, input drive, input clamped, output ready);
endinterface

### sv/pdr_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive regulator bit-serial multiplier
// Shift-and-add product of a signed operand and an unsigned 16-bit operand,
// one bit of the unsigned operand per cycle.
// ----------------------------------------------------------------------------
module pdr_serial_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  pdr_pkg::mul_req_type  req,
   output pdr_pkg::mul_rsp_type  rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [pdr_pkg::MUL_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pdr_pkg::MUL_P_W-1:0]         a_sh_ff, a_sh_in;
   logic [pdr_pkg::MUL_B_W-1:0]         b_sh_ff, b_sh_in;
   logic [pdr_pkg::MUL_P_W-1:0]         acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_sh_in = {{pdr_pkg::MUL_B_W{req.a[pdr_pkg::MUL_A_W-1]}}, req.a};
         b_sh_in = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = {a_sh_ff[pdr_pkg::MUL_P_W-2:0], 1'b0};
         b_sh_in = {1'b0, b_sh_ff[pdr_pkg::MUL_B_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == pdr_pkg::MUL_CNT_W'(pdr_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = $signed(acc_ff);

endmodule

### sv/pdr_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive regulator bit-serial divider
// Restoring division of a signed dividend by an unsigned divisor, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pdr_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pdr_pkg::div_req_type  req,
   output pdr_pkg::div_rsp_type  rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                neg_ff, neg_in;
   logic [pdr_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pdr_pkg::DIV_MAG_W-1:0]       quo_ff, quo_in;
   logic [pdr_pkg::DIV_D_W-1:0]         rem_ff, rem_in;
   logic [pdr_pkg::DIV_D_W-1:0]         den_ff, den_in;
   logic [pdr_pkg::DIV_N_W-1:0]         mag;
   logic [pdr_pkg::DIV_D_W:0]           shifted;
   logic [pdr_pkg::DIV_D_W+1:0]         trial;
   logic [pdr_pkg::DIV_N_W-1:0]         quo_ext;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      mag     = req.dividend[pdr_pkg::DIV_N_W-1] ? -req.dividend : req.dividend;
      shifted = {rem_ff, quo_ff[pdr_pkg::DIV_MAG_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.dividend[pdr_pkg::DIV_N_W-1];
         cnt_in  = '0;
         quo_in  = mag[pdr_pkg::DIV_MAG_W-1:0];
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits in
         // the divisor width after either outcome.
         if (!trial[pdr_pkg::DIV_D_W+1]) begin
            rem_in = trial[pdr_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[pdr_pkg::DIV_MAG_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[pdr_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[pdr_pkg::DIV_MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pdr_pkg::DIV_CNT_W'(pdr_pkg::DIV_MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo_ext      = {1'b0, quo_ff};
   assign rsp.done     = done_ff;
   assign rsp.quotient = $signed(neg_ff ? -quo_ext : quo_ext);

endmodule

### sv/pid_drive_regulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive regulator
// Fixed-point PID regulator with conditional integration, built around one
// shared bit-serial multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Each error sample is worked through in sequence: five 16-step multiplies
// and two 58-step divides, of which the derivative divide is skipped when
// elapsed_ms is zero. A finished drive value sits in an output register,
// so the next sample is taken while the previous result still waits to be
// collected.
module pid_drive_regulator_top (
   input  logic                              clock,
   input  logic                              reset,
   pdr_req_if.sink                           req_ch,
   pdr_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [pdr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdr_pkg::CSR_W-1:0]         csr_wdata
);

   // Configuration registers
   logic [pdr_pkg::GAIN_W-1:0]   kp_ff, ki_ff, kd_ff;
   logic [pdr_pkg::THR_W-1:0]    thr_ff;
   logic [pdr_pkg::LIM_W-1:0]    lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= pdr_pkg::PROP_GAIN_RST;
         ki_ff  <= pdr_pkg::INTEG_GAIN_RST;
         kd_ff  <= pdr_pkg::DERIV_GAIN_RST;
         thr_ff <= pdr_pkg::INTEG_THR_RST;
         lim_ff <= pdr_pkg::OUTPUT_LIM_RST;
      end else if (csr_we) begin
         case (csr_index)
            pdr_pkg::CSR_PROP_GAIN:  kp_ff  <= csr_wdata;
            pdr_pkg::CSR_INTEG_GAIN: ki_ff  <= csr_wdata;
            pdr_pkg::CSR_DERIV_GAIN: kd_ff  <= csr_wdata;
            pdr_pkg::CSR_INTEG_THR:  thr_ff <= csr_wdata[pdr_pkg::THR_W-1:0];
            pdr_pkg::CSR_OUTPUT_LIM: lim_ff <= csr_wdata[pdr_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and working registers
   pdr_pkg::state_type                       state_ff, state_in;
   logic                                     go_ff, go_in;
   logic signed [pdr_pkg::ERR_W-1:0]         e_ff, e_in;
   logic [pdr_pkg::MS_W-1:0]                 ms_ff, ms_in;
   logic signed [pdr_pkg::INTEG_W-1:0]       p_ff, p_in;
   logic signed [pdr_pkg::MUL_P_W-1:0]       t_ff, t_in;
   logic signed [pdr_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic signed [pdr_pkg::INTEG_W-1:0]       integ_ff, integ_in;
   logic signed [pdr_pkg::ERR_W-1:0]         last_ff, last_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [pdr_pkg::DRIVE_W-1:0]       drive_ff, drive_in;
   logic                                     clamped_ff, clamped_in;

   pdr_pkg::mul_req_type                     mul_req;
   pdr_pkg::mul_rsp_type                     mul_rsp;
   pdr_pkg::div_req_type                     div_req;
   pdr_pkg::div_rsp_type                     div_rsp;

   logic                                     req_fire;
   logic                                     slot_free;
   logic signed [pdr_pkg::DIFF_W-1:0]        diff;
   logic signed [pdr_pkg::INTEG_W-1:0]       thr_q24;
   logic signed [pdr_pkg::INTEG_W:0]         integ_acc;
   logic signed [pdr_pkg::WHOLE_W-1:0]       whole;
   logic signed [pdr_pkg::WHOLE_W-1:0]       pos_lim;
   logic signed [pdr_pkg::WHOLE_W-1:0]       neg_lim;
   logic                                     round_up;

   assign req_ch.ready = (state_ff == pdr_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign diff      = {e_ff[pdr_pkg::ERR_W-1], e_ff} - {last_ff[pdr_pkg::ERR_W-1], last_ff};
   assign thr_q24   = {{(pdr_pkg::INTEG_W - pdr_pkg::THR_W - pdr_pkg::Q_SHIFT)
                         {thr_ff[pdr_pkg::THR_W-1]}}, thr_ff, {pdr_pkg::Q_SHIFT{1'b0}}};
   assign integ_acc = {integ_ff[pdr_pkg::INTEG_W-1], integ_ff}
                    + {t_ff[pdr_pkg::INTEG_W-1], t_ff[pdr_pkg::INTEG_W-1:0]};

   // Truncation toward zero: a negative sum with a fractional part rounds up.
   assign round_up = sum_ff[pdr_pkg::SUM_W-1] && (|sum_ff[pdr_pkg::Q_SHIFT-1:0]);
   assign whole    = sum_ff[pdr_pkg::SUM_W-1:pdr_pkg::Q_SHIFT]
                   + {{(pdr_pkg::WHOLE_W-1){1'b0}}, round_up};
   assign pos_lim  = {{(pdr_pkg::WHOLE_W - pdr_pkg::LIM_W){1'b0}}, lim_ff};
   assign neg_lim  = -pos_lim;

   // Operand selection for the shared units
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      div_req.start = 1'b0;
      div_req.dividend = t_ff[pdr_pkg::DIV_N_W-1:0];
      div_req.divisor  = pdr_pkg::MS_PER_S;
      case (state_ff)
         pdr_pkg::ST_P_MUL: begin
            mul_req.start = go_ff;
            mul_req.a = {{(pdr_pkg::MUL_A_W - pdr_pkg::ERR_W){e_ff[pdr_pkg::ERR_W-1]}}, e_ff};
            mul_req.b = kp_ff;
         end
         pdr_pkg::ST_E_MUL: begin
            mul_req.start = go_ff;
            mul_req.a = {{(pdr_pkg::MUL_A_W - pdr_pkg::ERR_W){e_ff[pdr_pkg::ERR_W-1]}}, e_ff};
            mul_req.b = ms_ff;
         end
         pdr_pkg::ST_I_DIV: begin
            div_req.start = go_ff;
         end
         pdr_pkg::ST_I_MUL: begin
            mul_req.start = go_ff;
            mul_req.a = {{(pdr_pkg::MUL_A_W - pdr_pkg::INTEG_W){integ_ff[pdr_pkg::INTEG_W-1]}},
                         integ_ff};
            mul_req.b = ki_ff;
         end
         pdr_pkg::ST_D_MUL1: begin
            mul_req.start = go_ff;
            mul_req.a = {{(pdr_pkg::MUL_A_W - pdr_pkg::DIFF_W){diff[pdr_pkg::DIFF_W-1]}}, diff};
            mul_req.b = kd_ff;
         end
         pdr_pkg::ST_D_MUL2: begin
            mul_req.start = go_ff;
            mul_req.a = t_ff[pdr_pkg::MUL_A_W-1:0];
            mul_req.b = pdr_pkg::MS_PER_S;
         end
         pdr_pkg::ST_D_DIV: begin
            div_req.start   = go_ff;
            div_req.divisor = ms_ff;
         end
         default: ;
      endcase
   end

   pdr_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   pdr_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      e_in         = e_ff;
      ms_in        = ms_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      drive_in     = drive_ff;
      clamped_in   = clamped_ff;
      case (state_ff)
         pdr_pkg::ST_IDLE: begin
            if (req_fire) begin
               e_in  = req_ch.error_sample;
               ms_in = req_ch.elapsed_ms;
               if (req_ch.restart) begin
                  integ_in = '0;
                  last_in  = '0;
               end
               state_in = pdr_pkg::ST_P_MUL;
               go_in    = 1'b1;
            end
         end
         pdr_pkg::ST_P_MUL: begin
            if (mul_rsp.done) begin
               p_in     = mul_rsp.product[pdr_pkg::INTEG_W-1:0];
               sum_in   = mul_rsp.product;
               state_in = pdr_pkg::ST_E_MUL;
               go_in    = 1'b1;
            end
         end
         pdr_pkg::ST_E_MUL: begin
            if (mul_rsp.done) begin
               t_in     = mul_rsp.product;
               state_in = pdr_pkg::ST_I_DIV;
               go_in    = 1'b1;
            end
         end
         pdr_pkg::ST_I_DIV: begin
            if (div_rsp.done) begin
               t_in = {{(pdr_pkg::MUL_P_W - pdr_pkg::DIV_N_W)
                        {div_rsp.quotient[pdr_pkg::DIV_N_W-1]}}, div_rsp.quotient};
               state_in = pdr_pkg::ST_I_UPD;
            end
         end
         pdr_pkg::ST_I_UPD: begin
            // Integrate only while the proportional term is under threshold.
            if (p_ff < thr_q24) begin
               if (integ_acc[pdr_pkg::INTEG_W] != integ_acc[pdr_pkg::INTEG_W-1]) begin
                  integ_in = integ_acc[pdr_pkg::INTEG_W]
                           ? {1'b1, {(pdr_pkg::INTEG_W-1){1'b0}}}
                           : {1'b0, {(pdr_pkg::INTEG_W-1){1'b1}}};
               end else begin
                  integ_in = integ_acc[pdr_pkg::INTEG_W-1:0];
               end
            end
            state_in = pdr_pkg::ST_I_MUL;
            go_in    = 1'b1;
         end
         pdr_pkg::ST_I_MUL: begin
            if (mul_rsp.done) begin
               sum_in   = sum_ff + mul_rsp.product;
               state_in = pdr_pkg::ST_D_MUL1;
               go_in    = 1'b1;
            end
         end
         pdr_pkg::ST_D_MUL1: begin
            if (mul_rsp.done) begin
               t_in     = mul_rsp.product;
               last_in  = e_ff;
               state_in = pdr_pkg::ST_D_MUL2;
               go_in    = 1'b1;
            end
         end
         pdr_pkg::ST_D_MUL2: begin
            if (mul_rsp.done) begin
               t_in = mul_rsp.product;
               if (ms_ff == '0) begin
                  state_in = pdr_pkg::ST_FINISH;
               end else begin
                  state_in = pdr_pkg::ST_D_DIV;
                  go_in    = 1'b1;
               end
            end
         end
         pdr_pkg::ST_D_DIV: begin
            if (div_rsp.done) begin
               sum_in = sum_ff + {{(pdr_pkg::SUM_W - pdr_pkg::DIV_N_W)
                                   {div_rsp.quotient[pdr_pkg::DIV_N_W-1]}}, div_rsp.quotient};
               state_in = pdr_pkg::ST_FINISH;
            end
         end
         pdr_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (whole > pos_lim) begin
                  drive_in   = pos_lim[pdr_pkg::DRIVE_W-1:0];
                  clamped_in = 1'b1;
               end else if (whole < neg_lim) begin
                  drive_in   = neg_lim[pdr_pkg::DRIVE_W-1:0];
                  clamped_in = 1'b1;
               end else begin
                  drive_in   = whole[pdr_pkg::DRIVE_W-1:0];
                  clamped_in = 1'b0;
               end
               state_in = pdr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdr_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
      e_ff       <= e_in;
      ms_ff      <= ms_in;
      p_ff       <= p_in;
      t_ff       <= t_in;
      sum_ff     <= sum_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.drive   = drive_ff;
   assign rsp_ch.clamped = clamped_ff;

`ifndef SYNTHESIS
   // A unit reports completion only while the sequencer waits on that unit.
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == pdr_pkg::ST_P_MUL || state_ff == pdr_pkg::ST_E_MUL ||
                        state_ff == pdr_pkg::ST_I_MUL || state_ff == pdr_pkg::ST_D_MUL1 ||
                        state_ff == pdr_pkg::ST_D_MUL2))
      else $error("multiplier completed outside a multiply step");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pdr_pkg::ST_I_DIV || state_ff == pdr_pkg::ST_D_DIV))
      else $error("divider completed outside a divide step");

   // A restart transfer leaves the integral and previous error cleared.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.restart |=> (integ_ff == '0 && last_ff == '0))
      else $error("restart did not clear the regulator state");

   // A unit is launched once per step.
   assert property (@(posedge clock) disable iff (reset)
      go_ff |=> !go_ff)
      else $error("arithmetic unit launched twice");
`endif

endmodule
